>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/c2d_pkg.sv
package c2d_pkg;

  localparam int unsigned KSIZE      = 5;
  localparam int          KHALF      = (KSIZE / 2 > 2) ? 2 : KSIZE / 2;
  localparam int unsigned NTAP       = 5;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  localparam int unsigned COLX_W     = ADDR_W + 2;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned COEF_W     = 12;
  localparam int unsigned KROW_W     = 60;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned ROWX_W     = HEIGHT_W + 1;
  localparam int unsigned FILL_W     = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned PROD_W     = 29;
  localparam int unsigned RSUM_W     = 32;
  localparam int unsigned TSUM_W     = 35;
  localparam int unsigned FRAC_W     = 10;
  localparam int unsigned OUT_W      = 18;
  localparam int          OUT_MAX    = 2 ** (OUT_W - 1) - 1;
  localparam int          OUT_MIN    = -(2 ** (OUT_W - 1));
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);
  localparam logic [KROW_W-1:0]   KROW_CENTER  = KROW_W'(64'd17179869184);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_KROW0  = 3'd2,
    CFG_KROW1  = 3'd3,
    CFG_KROW2  = 3'd4,
    CFG_KROW3  = 3'd5,
    CFG_KROW4  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              en;
    logic              bypass;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
  } line_ctrl_t;

  typedef struct packed {
    logic            row_ok;
    logic [NTAP-1:0] col_ok;
  } tap_mask_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    frame_last;
  } result_t;

endpackage

>>> rtl/c2d_cell.sv
module c2d_cell (
  input  logic                                clk_i,
  input  c2d_pkg::line_ctrl_t                 ctrl_i,
  input  logic [c2d_pkg::PIX_W-1:0]           pix_i,
  input  logic [c2d_pkg::KROW_W-1:0]          coef_i,
  input  c2d_pkg::tap_mask_t                  mask_i,
  output logic [c2d_pkg::PIX_W-1:0]           pix_o,
  output logic signed [c2d_pkg::RSUM_W-1:0]   row_sum_o
);

  logic [c2d_pkg::PIX_W-1:0]         line_mem [c2d_pkg::MAX_WIDTH];
  logic [c2d_pkg::PIX_W-1:0]         rd_q;
  logic [c2d_pkg::PIX_W-1:0]         taps_q [c2d_pkg::NTAP];
  logic signed [c2d_pkg::PROD_W-1:0] tap_ext [c2d_pkg::NTAP];
  logic signed [c2d_pkg::PROD_W-1:0] coef_ext [c2d_pkg::NTAP];
  logic signed [c2d_pkg::PROD_W-1:0] prod_d [c2d_pkg::NTAP];
  logic signed [c2d_pkg::PROD_W-1:0] prod_q [c2d_pkg::NTAP];
  logic signed [c2d_pkg::RSUM_W-1:0] row_sum_d;
  logic signed [c2d_pkg::RSUM_W-1:0] row_sum_q;

  // The line memory delays the pixel stream by exactly one image row.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      line_mem[ctrl_i.wr_addr] <= pix_i;
      rd_q <= ctrl_i.bypass ? pix_i : line_mem[ctrl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      taps_q[0] <= pix_i;
      for (int t = 1; t < c2d_pkg::NTAP; t++) begin
        taps_q[t] <= taps_q[t-1];
      end
    end
  end

  always_comb begin
    for (int t = 0; t < c2d_pkg::NTAP; t++) begin
      tap_ext[t]  = signed'(c2d_pkg::PROD_W'(taps_q[t]));
      coef_ext[t] = c2d_pkg::PROD_W'(signed'(coef_i[t*c2d_pkg::COEF_W +: c2d_pkg::COEF_W]));
      if (mask_i.row_ok && mask_i.col_ok[t]) begin
        prod_d[t] = tap_ext[t] * coef_ext[t];
      end else begin
        prod_d[t] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < c2d_pkg::NTAP; t++) begin
      prod_q[t] <= prod_d[t];
    end
  end

  always_comb begin
    row_sum_d = '0;
    for (int t = 0; t < c2d_pkg::NTAP; t++) begin
      row_sum_d = row_sum_d + c2d_pkg::RSUM_W'(prod_q[t]);
    end
  end

  always_ff @(posedge clk_i) begin
    row_sum_q <= row_sum_d;
  end

  assign pix_o     = rd_q;
  assign row_sum_o = row_sum_q;

endmodule

>>> rtl/c2d_out_fifo.sv
module c2d_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  c2d_pkg::result_t wr_data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output c2d_pkg::result_t data_o
);

  c2d_pkg::result_t                  store_q [c2d_pkg::FIFO_DEPTH];
  logic [c2d_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [c2d_pkg::FIFO_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [c2d_pkg::CNT_W-1:0]         count_q, count_d;
  logic                              rd_en;

  assign valid_o = (count_q != '0);
  assign rd_en   = valid_o && !stall_i;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + c2d_pkg::CNT_W'(wr_en_i) - c2d_pkg::CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/conv2d_zero_padded_stream.sv
// Same-size 5x5 convolution with zero padding on a raster pixel stream. One pixel transfer is
// taken per clock unless stalled. Results pass the tap, product, row-sum and total registers
// into the output queue and are offered on the next clock. The first 2*width+2 transfers of
// each frame give no result, so the host follows every frame with that many fill transfers.
// Five row cells each hold five window taps, a one-row line memory and a row of multipliers;
// the output queue holds eight results, and the input stalls while eight results are owed
// downstream. The user must write configuration only while the block is idle; not enforced.
`include "assert_macros.svh"

module conv2d_zero_padded_stream (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [c2d_pkg::KROW_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [c2d_pkg::PIX_W-1:0]           pixel_in_i,
  input  logic                                is_fill_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [c2d_pkg::OUT_W-1:0]    filtered_o,
  output logic                                frame_last_o
);

  logic [c2d_pkg::WIDTH_W-1:0]   w_q, w_eff;
  logic [c2d_pkg::HEIGHT_W-1:0]  h_q, h_eff;
  logic [c2d_pkg::KROW_W-1:0]    krow_q [c2d_pkg::NTAP];
  logic [c2d_pkg::CFG_IDX_W-1:0] krow_sel;
  logic                          size_wr;

  logic [c2d_pkg::ADDR_W-1:0]    ptr_q, ptr_nxt;
  logic [c2d_pkg::ADDR_W-1:0]    col_q;
  logic [c2d_pkg::HEIGHT_W-1:0]  row_q;
  logic [c2d_pkg::FILL_W-1:0]    fill_cnt_q, lag;
  logic [c2d_pkg::COLX_W-1:0]    col_base;
  logic [c2d_pkg::ROWX_W-1:0]    row_base;

  logic                          accept, has_res, is_last, out_acc;
  logic [c2d_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [c2d_pkg::PIX_W-1:0]     pix;

  c2d_pkg::line_ctrl_t           line_ctrl;
  c2d_pkg::tap_mask_t            mask_d [c2d_pkg::NTAP];
  c2d_pkg::tap_mask_t            mask_q [c2d_pkg::NTAP];
  logic [c2d_pkg::PIX_W-1:0]     chain [c2d_pkg::NTAP];
  logic signed [c2d_pkg::RSUM_W-1:0] row_sum [c2d_pkg::NTAP];

  logic                          v0_q, v1_q, v2_q, v3_q;
  logic                          last0_q, last1_q, last2_q, last3_q;
  logic signed [c2d_pkg::TSUM_W-1:0] total_d, total_q, shifted;
  c2d_pkg::result_t              res_d, fifo_out;

  // Configuration
  always_comb begin
    w_eff = cfg_data_i[c2d_pkg::WIDTH_W-1:0];
    if (w_eff == '0) begin
      w_eff = c2d_pkg::WIDTH_W'(1);
    end else if (w_eff > c2d_pkg::WIDTH_W'(c2d_pkg::MAX_WIDTH)) begin
      w_eff = c2d_pkg::WIDTH_W'(c2d_pkg::MAX_WIDTH);
    end
    h_eff = cfg_data_i[c2d_pkg::HEIGHT_W-1:0];
    if (h_eff == '0) begin
      h_eff = c2d_pkg::HEIGHT_W'(1);
    end else if (h_eff > c2d_pkg::HEIGHT_W'(c2d_pkg::MAX_HEIGHT)) begin
      h_eff = c2d_pkg::HEIGHT_W'(c2d_pkg::MAX_HEIGHT);
    end
  end

  assign krow_sel = cfg_idx_i - c2d_pkg::CFG_IDX_W'(c2d_pkg::CFG_KROW0);
  assign size_wr  = cfg_we_i && (cfg_idx_i == c2d_pkg::CFG_WIDTH ||
                                 cfg_idx_i == c2d_pkg::CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= c2d_pkg::WIDTH_RESET;
      h_q <= c2d_pkg::HEIGHT_RESET;
      for (int j = 0; j < c2d_pkg::NTAP; j++) begin
        krow_q[j] <= '0;
      end
      krow_q[2] <= c2d_pkg::KROW_CENTER;
    end else if (cfg_we_i) begin
      unique case (c2d_pkg::cfg_idx_e'(cfg_idx_i)) inside
        c2d_pkg::CFG_WIDTH: begin
          w_q <= w_eff;
        end
        c2d_pkg::CFG_HEIGHT: begin
          h_q <= h_eff;
        end
        c2d_pkg::CFG_KROW0, c2d_pkg::CFG_KROW1, c2d_pkg::CFG_KROW2,
        c2d_pkg::CFG_KROW3, c2d_pkg::CFG_KROW4: begin
          krow_q[krow_sel] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Frame position and line memory addressing
  assign pix     = is_fill_i ? '0 : pixel_in_i;
  assign accept  = in_valid_i && !in_stall_o;
  assign lag     = c2d_pkg::FILL_W'(w_q) + c2d_pkg::FILL_W'(w_q) + c2d_pkg::FILL_W'(2);
  assign has_res = (fill_cnt_q == lag);
  assign is_last = has_res && (row_q == h_q - c2d_pkg::HEIGHT_W'(1)) &&
                   (c2d_pkg::COLX_W'(col_q) == c2d_pkg::COLX_W'(w_q) - c2d_pkg::COLX_W'(1));

  assign ptr_nxt = (c2d_pkg::COLX_W'(ptr_q) + c2d_pkg::COLX_W'(1) == c2d_pkg::COLX_W'(w_q)) ?
                   '0 : ptr_q + 1'b1;

  always_comb begin
    line_ctrl.en      = accept;
    line_ctrl.bypass  = (ptr_nxt == ptr_q);
    line_ctrl.wr_addr = ptr_q;
    line_ctrl.rd_addr = ptr_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      fill_cnt_q <= '0;
    end else if (size_wr) begin
      ptr_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      fill_cnt_q <= '0;
    end else if (accept) begin
      ptr_q <= ptr_nxt;
      if (!has_res) begin
        fill_cnt_q <= fill_cnt_q + 1'b1;
      end else if (is_last) begin
        col_q      <= '0;
        row_q      <= '0;
        fill_cnt_q <= '0;
      end else if (c2d_pkg::COLX_W'(col_q) + c2d_pkg::COLX_W'(1) ==
                   c2d_pkg::COLX_W'(w_q)) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Border masks: cell j sees image row row+2-j, tap t sees column col+2-t.
  assign col_base = c2d_pkg::COLX_W'(col_q) + c2d_pkg::COLX_W'(2);
  assign row_base = c2d_pkg::ROWX_W'(row_q) + c2d_pkg::ROWX_W'(2);

  always_comb begin
    for (int j = 0; j < c2d_pkg::NTAP; j++) begin
      mask_d[j].row_ok = (row_base >= c2d_pkg::ROWX_W'(j)) &&
                         (row_base - c2d_pkg::ROWX_W'(j) < c2d_pkg::ROWX_W'(h_q)) &&
                         (j >= 2 - c2d_pkg::KHALF) && (j <= 2 + c2d_pkg::KHALF);
      for (int t = 0; t < c2d_pkg::NTAP; t++) begin
        mask_d[j].col_ok[t] = (col_base >= c2d_pkg::COLX_W'(t)) &&
                              (col_base - c2d_pkg::COLX_W'(t) < c2d_pkg::COLX_W'(w_q)) &&
                              (t >= 2 - c2d_pkg::KHALF) && (t <= 2 + c2d_pkg::KHALF);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int j = 0; j < c2d_pkg::NTAP; j++) begin
        mask_q[j] <= mask_d[j];
      end
    end
  end

  // Row cells
  assign chain[0] = pix;

  for (genvar j = 0; j < c2d_pkg::NTAP; j++) begin : g_cell
    if (j < c2d_pkg::NTAP - 1) begin : g_mid
      c2d_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (line_ctrl),
        .pix_i     (chain[j]),
        .coef_i    (krow_q[j]),
        .mask_i    (mask_q[j]),
        .pix_o     (chain[j+1]),
        .row_sum_o (row_sum[j])
      );
    end else begin : g_end
      c2d_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (line_ctrl),
        .pix_i     (chain[j]),
        .coef_i    (krow_q[j]),
        .mask_i    (mask_q[j]),
        .pix_o     (),
        .row_sum_o (row_sum[j])
      );
    end
  end

  // Result pipeline
  always_comb begin
    total_d = '0;
    for (int j = 0; j < c2d_pkg::NTAP; j++) begin
      total_d = total_d + c2d_pkg::TSUM_W'(row_sum[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    last0_q <= is_last;
    last1_q <= last0_q;
    last2_q <= last1_q;
    last3_q <= last2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= accept && has_res;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign shifted = total_q >>> c2d_pkg::FRAC_W;

  always_comb begin
    if (shifted > c2d_pkg::TSUM_W'(c2d_pkg::OUT_MAX)) begin
      res_d.filtered = c2d_pkg::OUT_W'(c2d_pkg::OUT_MAX);
    end else if (shifted < c2d_pkg::TSUM_W'(c2d_pkg::OUT_MIN)) begin
      res_d.filtered = c2d_pkg::OUT_W'(c2d_pkg::OUT_MIN);
    end else begin
      res_d.filtered = c2d_pkg::OUT_W'(shifted);
    end
    res_d.frame_last = last3_q;
  end

  c2d_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (v3_q),
    .wr_data_i (res_d),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .data_o    (fifo_out)
  );

  assign filtered_o   = fifo_out.filtered;
  assign frame_last_o = fifo_out.frame_last;

  // Results owed downstream, from input transfer to output transfer.
  assign out_acc    = out_valid_o && !out_stall_i;
  assign cnt_d      = cnt_q + c2d_pkg::CNT_W'(accept && has_res) - c2d_pkg::CNT_W'(out_acc);
  assign in_stall_o = (cnt_q >= c2d_pkg::CNT_W'(c2d_pkg::FIFO_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_ALWAYS(a_credit_bound, clk_i, rst_ni,
    cnt_q <= c2d_pkg::CNT_W'(c2d_pkg::FIFO_DEPTH), "result credit count overflow")
  `ASSERT_IMPL(a_out_has_credit, clk_i, rst_ni, out_valid_o, cnt_q != '0,
    "output offered without an owed result")
  `ASSERT_ALWAYS(a_col_in_range, clk_i, rst_ni,
    c2d_pkg::COLX_W'(col_q) < c2d_pkg::COLX_W'(w_q), "column counter beyond image width")
  `ASSERT_NEXT(a_frame_wrap, clk_i, rst_ni, accept && is_last && !cfg_we_i,
    col_q == '0 && row_q == '0 && fill_cnt_q == '0, "frame counters not cleared at frame end")

endmodule
